// File: rtl/u16u8_pkg.sv
package u16u8_pkg;

  // Input item: one UTF-16 code unit of a path
  typedef struct packed {
    logic [15:0] code_unit;
    logic        last_unit;
    logic        empty_path;
  } unit_in_t;

  // Result item: one UTF-8 byte or the status-only end of a path
  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       run_end;
    logic       path_done;
    logic [2:0] status;
  } result_t;

  // Work for the back end: the results caused by one accepted item
  typedef struct packed {
    logic [3:0][7:0] data;
    logic [2:0]      nbytes;
    logic [2:0]      byte_status;
    logic            has_end;
    logic [2:0]      end_status;
  } job_t;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_EMPTY      = 3'd1;
  localparam logic [2:0] ST_BAD_CHAR   = 3'd2;
  localparam logic [2:0] ST_BAD_SURR   = 3'd3;
  localparam logic [2:0] ST_ABSOLUTE   = 3'd4;
  localparam logic [2:0] ST_UNSAFE     = 3'd5;

  localparam logic [1:0] CC_EMPTY  = 2'd0;
  localparam logic [1:0] CC_DOT    = 2'd1;
  localparam logic [1:0] CC_DOTDOT = 2'd2;
  localparam logic [1:0] CC_OTHER  = 2'd3;

  localparam logic [15:0] HIGH_FIRST = 16'hD800;
  localparam logic [15:0] HIGH_LAST  = 16'hDBFF;
  localparam logic [15:0] LOW_FIRST  = 16'hDC00;
  localparam logic [15:0] LOW_LAST   = 16'hDFFF;
  localparam logic [15:0] UNIT_NUL   = 16'h0000;
  localparam logic [15:0] UNIT_BSLASH = 16'h005C;

  localparam logic [20:0] CP_SUPP_BASE = 21'h10000;
  localparam logic [20:0] CP_MAX1      = 21'h7F;
  localparam logic [20:0] CP_MAX2      = 21'h7FF;
  localparam logic [20:0] CP_MAX3      = 21'hFFFF;
  localparam logic [20:0] CP_SLASH     = 21'h2F;
  localparam logic [20:0] CP_DOT       = 21'h2E;

  localparam logic [7:0] LEAD2 = 8'hC0;
  localparam logic [7:0] LEAD3 = 8'hE0;
  localparam logic [7:0] LEAD4 = 8'hF0;
  localparam logic [7:0] CONT  = 8'h80;

endpackage

// File: rtl/utf16_path_to_utf8_checker_unit.sv
// UTF-16 path to UTF-8 transcoder and checker. Push one code unit per item;
// results come out one per cycle while pop is held, each a UTF-8 byte or,
// at the end of a path, one status-only item whose status is final (drop the
// bytes if it is not zero). An item is taken whenever the job queue of
// QueueDepth entries has room; it yields 0 to 5 results (4 bytes for a
// supplementary code point, plus 1 status-only result at the path end). The
// single-byte-per-cycle result port sets the sustained rate. Items that yield
// no result (a waiting high surrogate, units after an error) take no queue
// entry.
module utf16_path_to_utf8_checker_unit #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  u16u8_pkg::unit_in_t in_item_i,
  output logic                empty,
  input  logic                pop,
  output u16u8_pkg::result_t  out_item_o
);
  import u16u8_pkg::*;

  logic job_wr, q_full, q_empty, q_rd;
  job_t job_w, job_r;

  assign full = q_full;

  u16u8_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (push && !q_full),
    .item_i   (in_item_i),
    .job_wr_o (job_wr),
    .job_o    (job_w)
  );

  u16u8_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (job_wr),
    .wdata_i (job_w),
    .full_o  (q_full),
    .rd_i    (q_rd),
    .empty_o (q_empty),
    .rdata_o (job_r)
  );

  u16u8_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .q_data_i  (job_r),
    .q_rd_o    (q_rd),
    .empty_o   (empty),
    .pop_i     (pop),
    .result_o  (out_item_o)
  );

endmodule

// File: rtl/u16u8_front.sv
module u16u8_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  u16u8_pkg::unit_in_t item_i,
  output logic                job_wr_o,
  output u16u8_pkg::job_t     job_o
);
  import u16u8_pkg::*;

  logic [9:0]  ph_q, ph_d;
  logic        hw_q, hw_d;
  logic [2:0]  ue_q, ue_d;
  logic [2:0]  pe_q, pe_d;
  logic [1:0]  cc_q, cc_d;
  logic        start_q, start_d;

  logic [9:0]  t_ph;
  logic        t_hw;
  logic [2:0]  t_ue, t_pe, f_ue, f_pe;
  logic [1:0]  t_cc;
  logic        has_cp, is_high, is_low, ends, fin_start;
  logic [20:0] cp;
  logic [15:0] u;
  logic [2:0]  nb;
  logic [3:0][7:0] data;

  assign u       = item_i.code_unit;
  assign is_high = (u >= HIGH_FIRST) && (u <= HIGH_LAST);
  assign is_low  = (u >= LOW_FIRST) && (u <= LOW_LAST);
  assign ends    = item_i.empty_path || item_i.last_unit;

  always_comb begin
    t_ph   = ph_q;
    t_hw   = hw_q;
    t_ue   = ue_q;
    t_pe   = pe_q;
    t_cc   = cc_q;
    has_cp = 1'b0;
    cp     = '0;
    nb     = 3'd0;
    data   = '0;
    if (!item_i.empty_path) begin
      if (ue_q == ST_OK) begin
        if (hw_q) begin
          t_hw = 1'b0;
          if (!is_low) begin
            t_ue = ST_BAD_SURR;
          end else begin
            cp     = CP_SUPP_BASE + {1'b0, ph_q, u[9:0]};
            t_ph   = '0;
            has_cp = 1'b1;
          end
        end else if (u == UNIT_NUL || u == UNIT_BSLASH) begin
          t_ue = ST_BAD_CHAR;
        end else if (is_low) begin
          t_ue = ST_BAD_SURR;
        end else if (is_high) begin
          t_ph = u[9:0];
          t_hw = 1'b1;
        end else begin
          cp     = {5'd0, u};
          has_cp = 1'b1;
        end
      end
      if (has_cp) begin
        if (start_q && cp == CP_SLASH && t_pe == ST_OK) begin
          t_pe = ST_ABSOLUTE;
        end
        if (cp == CP_SLASH) begin
          if (t_cc != CC_OTHER && t_pe == ST_OK) begin
            t_pe = ST_UNSAFE;
          end
          t_cc = CC_EMPTY;
        end else if (cp == CP_DOT) begin
          if (t_cc != CC_OTHER) begin
            t_cc = t_cc + 2'd1;
          end
        end else begin
          t_cc = CC_OTHER;
        end
        if (cp <= CP_MAX1) begin
          nb      = 3'd1;
          data[0] = cp[7:0];
        end else if (cp <= CP_MAX2) begin
          nb      = 3'd2;
          data[0] = LEAD2 | {3'd0, cp[10:6]};
          data[1] = CONT | {2'd0, cp[5:0]};
        end else if (cp <= CP_MAX3) begin
          nb      = 3'd3;
          data[0] = LEAD3 | {4'd0, cp[15:12]};
          data[1] = CONT | {2'd0, cp[11:6]};
          data[2] = CONT | {2'd0, cp[5:0]};
        end else begin
          nb      = 3'd4;
          data[0] = LEAD4 | {5'd0, cp[20:18]};
          data[1] = CONT | {2'd0, cp[17:12]};
          data[2] = CONT | {2'd0, cp[11:6]};
          data[3] = CONT | {2'd0, cp[5:0]};
        end
      end
    end
  end

  // end-of-path checks run on the state left by this unit
  assign fin_start = item_i.empty_path && start_q;

  always_comb begin
    f_ue = t_ue;
    f_pe = t_pe;
    if (fin_start) begin
      f_ue = ST_EMPTY;
    end else begin
      if (t_hw && t_ue == ST_OK) begin
        f_ue = ST_BAD_SURR;
      end
      if (t_cc != CC_OTHER && t_pe == ST_OK) begin
        f_pe = ST_UNSAFE;
      end
    end
  end

  always_comb begin
    job_o.data        = data;
    job_o.nbytes      = nb;
    job_o.byte_status = (t_ue != ST_OK) ? t_ue : t_pe;
    job_o.has_end     = ends;
    job_o.end_status  = (f_ue != ST_OK) ? f_ue : f_pe;
  end

  assign job_wr_o = accept_i && (ends || nb != 3'd0);

  always_comb begin
    ph_d    = ph_q;
    hw_d    = hw_q;
    ue_d    = ue_q;
    pe_d    = pe_q;
    cc_d    = cc_q;
    start_d = start_q;
    if (accept_i) begin
      if (ends) begin
        ph_d    = '0;
        hw_d    = 1'b0;
        ue_d    = ST_OK;
        pe_d    = ST_OK;
        cc_d    = CC_EMPTY;
        start_d = 1'b1;
      end else begin
        ph_d    = t_ph;
        hw_d    = t_hw;
        ue_d    = t_ue;
        pe_d    = t_pe;
        cc_d    = t_cc;
        start_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q    <= '0;
      hw_q    <= 1'b0;
      ue_q    <= ST_OK;
      pe_q    <= ST_OK;
      cc_q    <= CC_EMPTY;
      start_q <= 1'b1;
    end else begin
      ph_q    <= ph_d;
      hw_q    <= hw_d;
      ue_q    <= ue_d;
      pe_q    <= pe_d;
      cc_q    <= cc_d;
      start_q <= start_d;
    end
  end

`ifndef SYNTHESIS
  a_hw_no_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hw_q |-> ue_q == ST_OK)
    else $error("high surrogate waiting after a unit error");
  a_start_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_q |-> (ue_q == ST_OK && pe_q == ST_OK && !hw_q && cc_q == CC_EMPTY))
    else $error("path start with leftover state");
`endif

endmodule

// File: rtl/u16u8_fifo.sv
module u16u8_fifo #(
  parameter int unsigned Depth = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_i,
  input  u16u8_pkg::job_t   wdata_i,
  output logic              full_o,
  input  logic              rd_i,
  output logic              empty_o,
  output u16u8_pkg::job_t   rdata_o
);
  import u16u8_pkg::*;

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);

  job_t            mem_q [Depth];
  logic [AW-1:0]   wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic            do_wr, do_rd;

  assign full_o  = (cnt_q == CW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_wr) begin
      wptr_d = (wptr_q == AW'(Depth - 1)) ? '0 : wptr_q + AW'(1);
    end
    if (do_rd) begin
      rptr_d = (rptr_q == AW'(Depth - 1)) ? '0 : rptr_q + AW'(1);
    end
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + CW'(1);
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_i |-> !full_o)
    else $error("job written into a full queue");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(Depth))
    else $error("queue count out of range");
`endif

endmodule

// File: rtl/u16u8_back.sv
module u16u8_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_empty_i,
  input  u16u8_pkg::job_t   q_data_i,
  output logic              q_rd_o,
  output logic              empty_o,
  input  logic              pop_i,
  output u16u8_pkg::result_t result_o
);
  import u16u8_pkg::*;

  job_t       job_q, job_d;
  logic       vld_q, vld_d;
  logic [2:0] idx_q, idx_d;
  logic [2:0] nres;
  logic       last_res, take;

  assign nres     = job_q.nbytes + {2'd0, job_q.has_end};
  assign last_res = (idx_q == nres - 3'd1);
  assign empty_o  = !vld_q;
  assign take     = !vld_q || (pop_i && last_res);
  assign q_rd_o   = take && !q_empty_i;

  always_comb begin
    result_o.run_end = last_res;
    if (idx_q < job_q.nbytes) begin
      result_o.out_byte   = job_q.data[idx_q[1:0]];
      result_o.byte_valid = 1'b1;
      result_o.path_done  = 1'b0;
      result_o.status     = job_q.byte_status;
    end else begin
      result_o.out_byte   = '0;
      result_o.byte_valid = 1'b0;
      result_o.path_done  = 1'b1;
      result_o.status     = job_q.end_status;
    end
  end

  always_comb begin
    job_d = job_q;
    vld_d = vld_q;
    idx_d = idx_q;
    if (take) begin
      vld_d = !q_empty_i;
      idx_d = 3'd0;
      if (!q_empty_i) begin
        job_d = q_data_i;
      end
    end else if (pop_i) begin
      idx_d = idx_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      idx_q <= 3'd0;
    end else begin
      vld_q <= vld_d;
      idx_q <= idx_d;
    end
  end

`ifndef SYNTHESIS
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q |-> (idx_q < nres))
    else $error("result index beyond the job");
  a_job_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q |-> (nres != 3'd0 && nres <= 3'd5))
    else $error("job with no results held");
`endif

endmodule

// File: dv/u16u8_result_checker.sv
`timescale 1ns / 1ps

module u16u8_result_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  logic                full_i,
  input  u16u8_pkg::unit_in_t unit_i,
  input  logic                empty_i,
  input  logic                pop_i,
  input  u16u8_pkg::result_t  result_i,
  output int                  fail_cnt_o,
  output int                  pending_o
);
  import u16u8_pkg::*;

  // Path tracking state
  logic [9:0] pend_high;
  logic       hi_waiting;
  logic [2:0] unit_err;
  logic [2:0] path_err;
  logic [1:0] comp_cls;
  logic       at_start;

  result_t utf8_expected[$];
  result_t step_results[5];
  int      step_cnt;
  result_t want;

  function automatic logic [2:0] path_status();
    return (unit_err != ST_OK) ? unit_err : path_err;
  endfunction

  task automatic clear_path();
    pend_high  = '0;
    hi_waiting = 1'b0;
    unit_err   = ST_OK;
    path_err   = ST_OK;
    comp_cls   = CC_EMPTY;
    at_start   = 1'b1;
  endtask

  task automatic stage_result(input logic [7:0] b, input logic vld, input logic done);
    result_t r;
    r.out_byte   = b;
    r.byte_valid = vld;
    r.run_end    = 1'b0;
    r.path_done  = done;
    r.status     = path_status();
    step_results[step_cnt] = r;
    step_cnt++;
  endtask

  task automatic track_component(input logic [20:0] cp);
    if (cp == CP_SLASH) begin
      if (comp_cls != CC_OTHER && path_err == ST_OK) path_err = ST_UNSAFE;
      comp_cls = CC_EMPTY;
    end else if (cp == CP_DOT) begin
      if (comp_cls != CC_OTHER) comp_cls = comp_cls + 2'd1;
    end else begin
      comp_cls = CC_OTHER;
    end
  endtask

  task automatic encode_utf8(input logic [20:0] cp);
    if (cp <= CP_MAX1) begin
      stage_result(cp[7:0], 1'b1, 1'b0);
    end else if (cp <= CP_MAX2) begin
      stage_result(LEAD2 | {3'd0, cp[10:6]}, 1'b1, 1'b0);
      stage_result(CONT | {2'd0, cp[5:0]}, 1'b1, 1'b0);
    end else if (cp <= CP_MAX3) begin
      stage_result(LEAD3 | {4'd0, cp[15:12]}, 1'b1, 1'b0);
      stage_result(CONT | {2'd0, cp[11:6]}, 1'b1, 1'b0);
      stage_result(CONT | {2'd0, cp[5:0]}, 1'b1, 1'b0);
    end else begin
      stage_result(LEAD4 | {5'd0, cp[20:18]}, 1'b1, 1'b0);
      stage_result(CONT | {2'd0, cp[17:12]}, 1'b1, 1'b0);
      stage_result(CONT | {2'd0, cp[11:6]}, 1'b1, 1'b0);
      stage_result(CONT | {2'd0, cp[5:0]}, 1'b1, 1'b0);
    end
  endtask

  task automatic take_unit(input logic [15:0] u);
    logic        first;
    logic        is_hi;
    logic        is_lo;
    logic        emits;
    logic [20:0] cp;
    first    = at_start;
    is_hi    = (u >= HIGH_FIRST) && (u <= HIGH_LAST);
    is_lo    = (u >= LOW_FIRST) && (u <= LOW_LAST);
    at_start = 1'b0;
    // once a unit error is latched, units are swallowed until the path ends
    if (unit_err == ST_OK) begin
      emits = 1'b1;
      cp    = {5'd0, u};
      if (hi_waiting) begin
        hi_waiting = 1'b0;
        if (!is_lo) begin
          unit_err = ST_BAD_SURR;
          emits    = 1'b0;
        end else begin
          cp        = CP_SUPP_BASE + {1'b0, pend_high, u[9:0]};
          pend_high = '0;
        end
      end else if (u == UNIT_NUL || u == UNIT_BSLASH) begin
        unit_err = ST_BAD_CHAR;
        emits    = 1'b0;
      end else if (is_lo) begin
        unit_err = ST_BAD_SURR;
        emits    = 1'b0;
      end else if (is_hi) begin
        pend_high  = u[9:0];
        hi_waiting = 1'b1;
        emits      = 1'b0;
      end
      if (emits) begin
        if (first && cp == CP_SLASH && path_err == ST_OK) path_err = ST_ABSOLUTE;
        track_component(cp);
        encode_utf8(cp);
      end
    end
  endtask

  task automatic end_path();
    if (at_start) begin
      unit_err = ST_EMPTY;
    end else begin
      if (hi_waiting && unit_err == ST_OK) unit_err = ST_BAD_SURR;
      if (comp_cls != CC_OTHER && path_err == ST_OK) path_err = ST_UNSAFE;
    end
    stage_result(8'h00, 1'b0, 1'b1);
    clear_path();
  endtask

  task automatic predict_utf8(input unit_in_t it);
    step_cnt = 0;
    if (it.empty_path) begin
      end_path();
    end else begin
      take_unit(it.code_unit);
      if (it.last_unit) end_path();
    end
    if (step_cnt > 0) begin
      step_results[step_cnt - 1].run_end = 1'b1;
      for (int i = 0; i < step_cnt; i++) begin
        utf8_expected.insert(utf8_expected.size(), step_results[i]);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_path();
      utf8_expected.delete();
      fail_cnt_o = 0;
      pending_o  = 0;
    end else begin
      if (push_i && !full_i) predict_utf8(unit_i);
      if (pop_i && !empty_i) begin
        if (utf8_expected.size() == 0) begin
          $display("%0t: unexpected result byte=%h vld=%b end=%b done=%b st=%0d",
                   $time, result_i.out_byte, result_i.byte_valid, result_i.run_end,
                   result_i.path_done, result_i.status);
          fail_cnt_o++;
        end else begin
          want = utf8_expected.pop_front();
          if (result_i !== want) begin
            $display("%0t: mismatch exp %h/%b/%b/%b/%0d got %h/%b/%b/%b/%0d",
                     $time, want.out_byte, want.byte_valid, want.run_end,
                     want.path_done, want.status, result_i.out_byte,
                     result_i.byte_valid, result_i.run_end, result_i.path_done,
                     result_i.status);
            fail_cnt_o++;
          end
        end
      end
      pending_o = utf8_expected.size();
    end
  end

endmodule

// File: dv/tb_utf16_path_to_utf8_checker_unit.sv
`timescale 1ns / 1ps

module tb_utf16_path_to_utf8_checker_unit;
  import u16u8_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned HOLD_CYCLES  = 120;
  localparam int unsigned PHASE_ITEMS  = 24;
  localparam int unsigned DRAIN_CYCLES = 16;

  localparam logic [15:0] U_SLASH = 16'h002F;
  localparam logic [15:0] U_DOT   = 16'h002E;

  // Defects injected into generated paths
  localparam int unsigned DEF_NONE        = 0;
  localparam int unsigned DEF_LEAD_SLASH  = 1;
  localparam int unsigned DEF_DOT         = 2;
  localparam int unsigned DEF_EMPTY_COMP  = 3;
  localparam int unsigned DEF_BAD_UNIT    = 4;
  localparam int unsigned DEF_LONE_LOW    = 5;
  localparam int unsigned DEF_HIGH_NO_LOW = 6;
  localparam int unsigned DEF_HIGH_AT_END = 7;
  localparam int unsigned DEF_END_BY_FLAG = 8;

  logic     clk_i   = 1'b0;
  logic     rst_ni  = 1'b0;
  logic     push    = 1'b0;
  logic     pop     = 1'b0;
  unit_in_t unit_in = '0;
  logic     full;
  logic     empty;
  result_t  result;
  int       fail_cnt;
  int       pending;

  int unsigned send_idle_pct = 0;
  int unsigned pop_stall_pct = 0;
  int unsigned cycle_cnt     = 0;
  logic        hold_on       = 1'b0;
  event        hold_ev;

  unit_in_t    path_units[$];
  logic [15:0] path_cu[$];

  utf16_path_to_utf8_checker_unit uut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push      (push),
    .full      (full),
    .in_item_i (unit_in),
    .empty     (empty),
    .pop       (pop),
    .out_item_o(result)
  );

  u16u8_result_checker result_chk (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .full_i    (full),
    .unit_i    (unit_in),
    .empty_i   (empty),
    .pop_i     (pop),
    .result_i  (result),
    .fail_cnt_o(fail_cnt),
    .pending_o (pending)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("tb_utf16_path_to_utf8_checker_unit NOT OK");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (hold_on) begin
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= pop_stall_pct);
    end
  end

  // long consumer hold-off so the job queue fills and the input stalls
  initial begin
    forever begin
      @(hold_ev);
      hold_on = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk_i);
      hold_on = 1'b0;
    end
  end

  task automatic add_unit(input logic [15:0] cu, input logic last, input logic empty_flag);
    unit_in_t it;
    it.code_unit  = cu;
    it.last_unit  = last;
    it.empty_path = empty_flag;
    path_units.insert(path_units.size(), it);
  endtask

  task automatic put_cu(input logic [15:0] cu);
    path_cu.insert(path_cu.size(), cu);
  endtask

  task automatic add_char();
    int unsigned cls;
    int unsigned r;
    cls = $urandom_range(9);
    if (cls < 5) begin
      do r = $urandom_range(16'h21, 16'h7E); while (r == U_SLASH || r == UNIT_BSLASH);
      put_cu(r[15:0]);
    end else if (cls < 7) begin
      r = $urandom_range(16'h80, 16'h7FF);
      put_cu(r[15:0]);
    end else if (cls < 9) begin
      r = $urandom_range(16'h800, 16'hF7FF);
      if (r >= HIGH_FIRST) r = r + 16'h800;
      put_cu(r[15:0]);
    end else begin
      r = $urandom_range(HIGH_FIRST, HIGH_LAST);
      put_cu(r[15:0]);
      r = $urandom_range(LOW_FIRST, LOW_LAST);
      put_cu(r[15:0]);
    end
  endtask

  task automatic build_path();
    int unsigned kind;
    int unsigned defect;
    int unsigned ncomp;
    int unsigned bad_comp;
    int unsigned len;
    int unsigned bad_pos;
    int unsigned r;
    unit_in_t    it;
    path_cu.delete();
    path_units.delete();
    kind = $urandom_range(99);
    if (kind < 6) begin
      // raw noise units with random flags
      len = $urandom_range(1, 6);
      for (int i = 0; i < len; i++) begin
        r             = $urandom;
        it.code_unit  = r[15:0];
        it.last_unit  = (r[17:16] == 2'b11) || (i == len - 1);
        it.empty_path = (r[21:18] == 4'hF);
        path_units.insert(path_units.size(), it);
      end
    end else if (kind < 10) begin
      r = $urandom;
      add_unit(r[15:0], r[16], 1'b1);
    end else begin
      defect   = ($urandom_range(99) < 70) ? DEF_NONE
                 : $urandom_range(DEF_LEAD_SLASH, DEF_END_BY_FLAG);
      ncomp    = $urandom_range((defect == DEF_EMPTY_COMP) ? 2 : 1, 3);
      bad_comp = $urandom_range(0, ncomp - 1);
      if (defect == DEF_LEAD_SLASH) put_cu(U_SLASH);
      for (int c = 0; c < ncomp; c++) begin
        if (c > 0) put_cu(U_SLASH);
        if (c == bad_comp && defect == DEF_DOT) begin
          put_cu(U_DOT);
          if ($urandom_range(1)) put_cu(U_DOT);
        end else if (!(c == bad_comp && defect == DEF_EMPTY_COMP)) begin
          len     = $urandom_range(1, 4);
          bad_pos = $urandom_range(0, len - 1);
          for (int k = 0; k < len; k++) begin
            if (c == bad_comp && k == bad_pos && defect == DEF_BAD_UNIT) begin
              put_cu($urandom_range(1) ? UNIT_NUL : UNIT_BSLASH);
            end else if (c == bad_comp && k == bad_pos && defect == DEF_LONE_LOW) begin
              r = $urandom_range(LOW_FIRST, LOW_LAST);
              put_cu(r[15:0]);
            end else if (c == bad_comp && k == bad_pos && defect == DEF_HIGH_NO_LOW) begin
              r = $urandom_range(HIGH_FIRST, HIGH_LAST);
              put_cu(r[15:0]);
              if ($urandom_range(3) == 0) put_cu(UNIT_BSLASH);
              else add_char();
            end else begin
              add_char();
            end
          end
        end
      end
      if (defect == DEF_HIGH_AT_END) begin
        r = $urandom_range(HIGH_FIRST, HIGH_LAST);
        put_cu(r[15:0]);
      end
      foreach (path_cu[i]) begin
        add_unit(path_cu[i], (i == path_cu.size() - 1) && (defect != DEF_END_BY_FLAG), 1'b0);
      end
      if (defect == DEF_END_BY_FLAG) begin
        r = $urandom;
        add_unit(r[15:0], r[16], 1'b1);
      end
    end
  endtask

  task automatic send_path();
    foreach (path_units[i]) begin
      unit_in <= path_units[i];
      push    <= 1'b1;
      @(posedge clk_i);
      while (full) @(posedge clk_i);
      if ($urandom_range(99) < send_idle_pct) begin
        push <= 1'b0;
        do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
      end
    end
  endtask

  initial begin
    int unsigned sent;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    path_units.delete();
    add_unit(16'hFFFF, 1'b1, 1'b1);     // empty flag wins over last_unit
    add_unit(16'h0061, 1'b1, 1'b0);
    // one path covering every encoding length and both surrogate extremes
    add_unit(16'h007F, 1'b0, 1'b0);
    add_unit(U_SLASH, 1'b0, 1'b0);
    add_unit(16'h0080, 1'b0, 1'b0);
    add_unit(16'h07FF, 1'b0, 1'b0);
    add_unit(16'h0800, 1'b0, 1'b0);
    add_unit(16'hFFFF, 1'b0, 1'b0);
    add_unit(HIGH_FIRST, 1'b0, 1'b0);
    add_unit(LOW_FIRST, 1'b0, 1'b0);
    add_unit(HIGH_LAST, 1'b0, 1'b0);
    add_unit(LOW_LAST, 1'b1, 1'b0);
    add_unit(U_SLASH, 1'b0, 1'b0);      // absolute path
    add_unit(16'h0078, 1'b1, 1'b0);
    add_unit(UNIT_BSLASH, 1'b0, 1'b0);  // units after a unit error give no bytes
    add_unit(16'h007A, 1'b1, 1'b0);
    add_unit(UNIT_NUL, 1'b1, 1'b0);
    add_unit(LOW_LAST, 1'b1, 1'b0);     // lone low surrogate
    add_unit(HIGH_FIRST, 1'b0, 1'b0);   // high not followed by a low
    add_unit(16'h0062, 1'b1, 1'b0);
    add_unit(HIGH_LAST, 1'b1, 1'b0);    // high left waiting at the end
    add_unit(U_DOT, 1'b0, 1'b0);        // ".." component, in a path ended by the empty flag
    add_unit(U_DOT, 1'b0, 1'b0);
    add_unit(U_SLASH, 1'b0, 1'b0);
    add_unit(16'h0063, 1'b0, 1'b0);
    add_unit(16'h0000, 1'b0, 1'b1);
    send_path();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 0;
          pop_stall_pct = 0;
          -> hold_ev;
        end
        1: begin
          send_idle_pct = 66;
          pop_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          pop_stall_pct = 66;
        end
        default: begin
          send_idle_pct = 12;
          pop_stall_pct = 12;
        end
      endcase
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        build_path();
        sent += path_units.size();
        send_path();
      end
    end
    push <= 1'b0;
    pop_stall_pct = 0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_cnt == 0 && pending == 0) begin
      $display("tb_utf16_path_to_utf8_checker_unit OK");
    end else begin
      $display("tb_utf16_path_to_utf8_checker_unit NOT OK");
    end
    $finish;
  end

endmodule
